// ===== src/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// ist_pkg - indent scope tokenizer shared types
// Beat layouts, lexer state, token kind codes, keyword table and the
// per-byte lexing function used by the tokenizer top level.
// ----------------------------------------------------------------------------
package ist_pkg;

	localparam int MAX_SCOPE_DEF = 15;
	localparam int NKEYS         = 12;
	localparam int KEY_MAX_LEN   = 10;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

	// Token kinds
	localparam logic [4:0] K_NUMBER  = 5'd0;
	localparam logic [4:0] K_WORD    = 5'd1;
	localparam logic [4:0] K_NEWLINE = 5'd2;
	localparam logic [4:0] K_LPAREN  = 5'd3;
	localparam logic [4:0] K_RPAREN  = 5'd4;
	localparam logic [4:0] K_COLON   = 5'd5;
	localparam logic [4:0] K_COMMA   = 5'd6;
	localparam logic [4:0] K_STRING  = 5'd7;
	localparam logic [4:0] K_EQ      = 5'd8;
	localparam logic [4:0] K_NE      = 5'd9;
	localparam logic [4:0] K_AT      = 5'd10;
	localparam logic [4:0] K_PLUS    = 5'd11;
	localparam logic [4:0] K_MINUS   = 5'd12;
	localparam logic [4:0] K_STAR    = 5'd13;
	localparam logic [4:0] K_SLASH   = 5'd14;
	localparam logic [4:0] K_PERCENT = 5'd15;
	localparam logic [4:0] K_KEYWORD = 5'd16;

	// Status codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_QUOTE    = 2'd1;
	localparam logic [1:0] ERR_INDENTED = 2'd2;

	// Characters
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PCT    = 8'h25;

	// Keywords, right-justified: byte p of a key sits at [8*(len-1-p) +: 8]
	localparam logic [8*KEY_MAX_LEN-1:0] KEY_TEXT [NKEYS] = '{
		80'("if"), 80'("else"), 80'("while"), 80'("foreach"), 80'("switch"),
		80'("return"), 80'("for"), 80'("pointer"), 80'("reference"),
		80'("async"), 80'("const"), 80'("safe")
	};
	localparam logic [3:0] KEY_LEN [NKEYS] = '{
		4'd2, 4'd4, 4'd5, 4'd7, 4'd6, 4'd6, 4'd3, 4'd7, 4'd9, 4'd5, 4'd5, 4'd4
	};

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_WORD,
		MODE_STRING,
		MODE_COMMENT
	} mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_file;
	} in_beat_t;

	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] token_byte;
		logic       token_first;
		logic       token_last;
		logic [3:0] scope;
		logic       stream_end;
		logic [1:0] error_code;
	} out_beat_t;

	typedef struct packed {
		logic [7:0]       held_byte;
		logic             held_valid;
		mode_t            mode;
		logic             prev_bs;
		logic [NKEYS-1:0] candidates;
		logic [3:0]       word_length;
		logic [3:0]       line_scope;
		logic             at_line_start;
		logic             last_nl;
	} lex_state_t;

	typedef struct packed {
		lex_state_t st;
		logic [1:0] cnt;
		out_beat_t  r0;
		out_beat_t  r1;
		logic       consumed;
	} lex_res_t;

	localparam lex_state_t ST_RESET = '{
		held_byte:     8'd0,
		held_valid:    1'b0,
		mode:          MODE_IDLE,
		prev_bs:       1'b0,
		candidates:    '1,
		word_length:   4'd0,
		line_scope:    4'd0,
		at_line_start: 1'b1,
		last_nl:       1'b0
	};

	function automatic logic is_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_lower(logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || (c == "_");
	endfunction

	// Single-byte tokens that need no lookahead
	function automatic logic [5:0] punct_kind(logic [7:0] c);
		logic [5:0] r;
		r = 6'd0;
		case (c)
			CH_LPAREN: r = {1'b1, K_LPAREN};
			CH_RPAREN: r = {1'b1, K_RPAREN};
			CH_COLON:  r = {1'b1, K_COLON};
			CH_COMMA:  r = {1'b1, K_COMMA};
			CH_AT:     r = {1'b1, K_AT};
			CH_PLUS:   r = {1'b1, K_PLUS};
			CH_MINUS:  r = {1'b1, K_MINUS};
			CH_STAR:   r = {1'b1, K_STAR};
			CH_PCT:    r = {1'b1, K_PERCENT};
			default:   r = 6'd0;
		endcase
		return r;
	endfunction

	// Lex one byte c with optional lookahead n.
	function automatic lex_res_t lex_step(lex_state_t s, logic [7:0] c, logic has_n,
			logic [7:0] n, logic [3:0] cap);
		lex_res_t   r;
		mode_t      m;
		logic       closing;
		logic       last;
		logic [3:0] pos;
		logic [4:0] kind;
		logic [5:0] pk;
		int         sh;
		r = '0;
		r.st = s;
		r.r0.scope = s.line_scope;
		r.r1.scope = s.line_scope;
		r.r0.token_byte = c;
		r.r1.token_byte = n;
		m = s.mode;
		pos = s.word_length;
		kind = K_WORD;
		if (s.mode == MODE_STRING) begin
			closing = (c == CH_QUOTE) && !s.prev_bs;
			r.cnt = 2'd1;
			r.r0.kind = K_STRING;
			r.r0.token_last = closing;
			r.st.at_line_start = 1'b0;
			if (closing) begin
				r.st.mode = MODE_IDLE;
				r.st.prev_bs = 1'b0;
			end else begin
				r.st.prev_bs = (c == CH_BSLASH) && !s.prev_bs;
			end
		end else if (!(s.mode == MODE_COMMENT && c != CH_NL)) begin
			if (s.mode == MODE_COMMENT)
				m = MODE_IDLE;
			r.st.mode = m;
			if (m == MODE_WORD || (m != MODE_NUMBER && is_lower(c))) begin
				last = !(has_n && (is_lower(n) || is_digit(n)));
				for (int k = 0; k < NKEYS; k++) begin
					if (pos >= KEY_LEN[k]) begin
						r.st.candidates[k] = 1'b0;
					end else begin
						sh = 8 * (int'(KEY_LEN[k]) - 1 - int'(pos));
						if (KEY_TEXT[k][sh +: 8] != c)
							r.st.candidates[k] = 1'b0;
					end
				end
				if (last) begin
					for (int k = 0; k < NKEYS; k++) begin
						if (r.st.candidates[k] && KEY_LEN[k] == pos + 4'd1)
							kind = K_KEYWORD + 5'(k);
					end
				end
				r.cnt = 2'd1;
				r.r0.kind = kind;
				r.r0.token_first = (m != MODE_WORD);
				r.r0.token_last = last;
				r.st.at_line_start = 1'b0;
				if (last) begin
					r.st.mode = MODE_IDLE;
					r.st.candidates = '1;
					r.st.word_length = 4'd0;
				end else begin
					r.st.mode = MODE_WORD;
					if (pos != 4'd15)
						r.st.word_length = pos + 4'd1;
				end
			end else if (m == MODE_NUMBER || is_digit(c)) begin
				last = !(has_n && is_digit(n));
				r.cnt = 2'd1;
				r.r0.kind = K_NUMBER;
				r.r0.token_first = (m != MODE_NUMBER);
				r.r0.token_last = last;
				r.st.at_line_start = 1'b0;
				r.st.mode = last ? MODE_IDLE : MODE_NUMBER;
			end else begin
				pk = punct_kind(c);
				if (c == CH_TAB) begin
					if (s.at_line_start && s.last_nl && s.line_scope < cap)
						r.st.line_scope = s.line_scope + 4'd1;
				end else if (c == CH_NL) begin
					if (!s.at_line_start) begin
						r.cnt = 2'd1;
						r.r0.kind = K_NEWLINE;
						r.r0.token_first = 1'b1;
						r.r0.token_last = 1'b1;
					end
					r.st.line_scope = 4'd0;
					r.st.at_line_start = 1'b1;
					r.st.last_nl = 1'b1;
				end else if (c == CH_QUOTE) begin
					r.cnt = 2'd1;
					r.r0.kind = K_STRING;
					r.r0.token_first = 1'b1;
					r.st.at_line_start = 1'b0;
					r.st.mode = MODE_STRING;
					r.st.prev_bs = 1'b0;
				end else if (c == CH_EQUAL || c == CH_BANG) begin
					// Two-byte operator: eat the lookahead too
					if (has_n && n == CH_EQUAL) begin
						r.cnt = 2'd2;
						r.r0.kind = (c == CH_EQUAL) ? K_EQ : K_NE;
						r.r1.kind = r.r0.kind;
						r.r0.token_first = 1'b1;
						r.r1.token_last = 1'b1;
						r.st.at_line_start = 1'b0;
						r.consumed = 1'b1;
					end
				end else if (c == CH_SLASH) begin
					if (has_n && n == CH_SLASH) begin
						r.st.mode = MODE_COMMENT;
					end else begin
						r.cnt = 2'd1;
						r.r0.kind = K_SLASH;
						r.r0.token_first = 1'b1;
						r.r0.token_last = 1'b1;
						r.st.at_line_start = 1'b0;
					end
				end else if (pk[5]) begin
					r.cnt = 2'd1;
					r.r0.kind = pk[4:0];
					r.r0.token_first = 1'b1;
					r.r0.token_last = 1'b1;
					r.st.at_line_start = 1'b0;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== src/indent_scope_tokenizer.sv =====
// A byte is held until the next beat is accepted, which queues its tokens.
// Throughput: one src beat per cycle unless src_stall; "==", "!=" and an end
//   beat that flushes a held byte give two tok beats, drained one per cycle
//   unless tok_stall from a 4-entry queue.
// src_stall rises while more than two results wait in that queue.
// Reset: arst_n clears the lexer state and empties the result queue.
// ----------------------------------------------------------------------------
// indent_scope_tokenizer - streaming lexer with indentation scope
// Classifies each source byte with one byte of lookahead and emits one
// beat per token byte, plus a status beat at end of file.
// ----------------------------------------------------------------------------
module indent_scope_tokenizer #(
	parameter int MAX_SCOPE = ist_pkg::MAX_SCOPE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  ist_pkg::in_beat_t   src_data,
	output logic                tok_valid,
	input  logic                tok_stall,
	output ist_pkg::out_beat_t  tok_data
);
	import ist_pkg::*;

	localparam logic [3:0] SCOPE_CAP = (MAX_SCOPE > 15) ? 4'd15 : 4'(MAX_SCOPE);

	lex_state_t              st_q;
	lex_state_t              st_d;
	lex_state_t              post;
	lex_res_t                lx;
	out_beat_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]      rd_ptr_q;
	logic [FIFO_AW-1:0]      wr_ptr_q;
	logic [FIFO_AW:0]        count_q;
	logic                    accept;
	logic                    pop;
	logic [1:0]              push_n;
	out_beat_t               push0;
	out_beat_t               push1;
	out_beat_t               status;
	logic [1:0]              flush_n;

	assign accept    = src_valid && !src_stall;
	assign src_stall = count_q > (FIFO_AW + 1)'(FIFO_DEPTH - 2);
	assign tok_valid = count_q != '0;
	assign tok_data  = fifo_q[rd_ptr_q];
	assign pop       = tok_valid && !tok_stall;

	always_comb begin
		lx = lex_step(st_q, st_q.held_byte, !src_data.end_of_file, src_data.ch, SCOPE_CAP);
		post = st_q.held_valid ? lx.st : st_q;
		flush_n = st_q.held_valid ? lx.cnt : 2'd0;
		status = '0;
		status.stream_end = 1'b1;
		if (post.mode == MODE_STRING)
			status.error_code = ERR_QUOTE;
		else if (post.line_scope != 4'd0)
			status.error_code = ERR_INDENTED;
		else
			status.error_code = ERR_NONE;

		st_d = st_q;
		push_n = 2'd0;
		push0 = lx.r0;
		push1 = lx.r1;
		if (accept) begin
			if (src_data.end_of_file) begin
				st_d = ST_RESET;
				if (flush_n == 2'd0) begin
					push0 = status;
					push_n = 2'd1;
				end else begin
					push1 = status;
					push_n = 2'd2;
				end
			end else if (!st_q.held_valid) begin
				st_d.held_byte = src_data.ch;
				st_d.held_valid = 1'b1;
			end else begin
				st_d = lx.st;
				push_n = lx.cnt;
				if (lx.consumed) begin
					st_d.held_byte = 8'd0;
					st_d.held_valid = 1'b0;
				end else begin
					st_d.held_byte = src_data.ch;
					st_d.held_valid = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_RESET;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			st_q     <= st_d;
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q  <= count_q + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
		end
	end

	// Result queue payload, no reset
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			fifo_q[wr_ptr_q] <= push0;
		if (push_n == 2'd2)
			fifo_q[wr_ptr_q + FIFO_AW'(1)] <= push1;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		FIFO_AW'(wr_ptr_q - rd_ptr_q) == count_q[FIFO_AW-1:0])
		else $error("queue pointers disagree with fill count");

	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_data.end_of_file |=> !st_q.held_valid && st_q.mode == MODE_IDLE
			&& st_q.line_scope == 4'd0)
		else $error("lexer state not cleared after end of file");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_data.stream_end |-> tok_data.token_byte == 8'd0
			&& tok_data.kind == K_NUMBER && tok_data.scope == 4'd0)
		else $error("status beat carries token fields");

endmodule
